>>> hdl/gptu_pkg.sv
// Shared types and constants for the graphics packet tag unpacker.
// No dependencies; imported by every module of the block.
package gptu_pkg;

    localparam int GPTU_QUEUE_DEPTH = 2;

    localparam logic [7:0] ADDR_PRIM  = 8'h00;
    localparam logic [7:0] ADDR_HWREG = 8'h54;

    localparam logic [1:0] FMT_IMAGE = 2'd2;

    localparam logic [3:0] DESC_AD    = 4'hE;
    localparam logic [3:0] DESC_NOP_B = 4'hB;
    localparam logic [3:0] DESC_NOP_F = 4'hF;

    localparam int TAG_PRE_BIT = 46;

    // One queued write command: dual sends v0 then v1 to HWREG.
    typedef struct packed {
        logic        dual;
        logic [7:0]  addr;
        logic [63:0] v0;
        logic [63:0] v1;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hdl/graphics_packet_tag_unpacker_top.sv
// Top level of the graphics packet tag unpacker: front, queue and back end.
// Depends on gptu_pkg, gptu_front, gptu_queue and gptu_back.
//
//   channel   dir   handshake            word
//   s_        in    s_tvalid/s_tready    128b quadword
//   m_        out   m_tvalid/m_tready    72b register write, m_tlast
//
// Front takes one quadword per cycle while the queue has room; tag decode
// and data classification finish in that cycle.
// Back emits one write word per cycle from its output register while m_tready
// is high; image quadwords become two write words on the single write port, others one.
// Words with no write (plain tag, descriptor B/F) leave nothing in the queue.
// Reset clears phase, counters, queue pointers and the output valid flag.
// Either side may stall; the queue of QUEUE_DEPTH commands absorbs it.
module graphics_packet_tag_unpacker_top
    import gptu_pkg::*;
#(
    parameter int QUEUE_DEPTH = GPTU_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // qword_low[63:0], qword_high[127:64]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,   // reg_address[7:0], reg_value[71:8]
    output logic          m_tlast
);

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    push;
    logic    pop;

    gptu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    gptu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    gptu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/gptu_front.sv
// Front end: accepts quadwords, tracks tag/data phase, classifies each word.
// Depends on gptu_pkg; pushes write commands into gptu_queue.
module gptu_front
    import gptu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  q_stat_t       q_stat,
    output logic          push,
    output cmd_t          push_cmd
);

    logic        phase_reg, phase_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [4:0]  rc_reg, rc_next;
    logic [63:0] list_reg, list_next;
    logic [18:0] idx_reg, idx_next;
    logic [18:0] total_reg, total_next;
    logic [3:0]  slot_reg, slot_next;

    logic [63:0] lo, hi;
    logic [3:0]  tag_n;
    logic [4:0]  tag_rc;
    logic [14:0] tag_loop;
    logic [1:0]  tag_fmt;
    logic [19:0] tag_prod;
    logic [18:0] tag_total;
    logic [18:0] idx_inc;
    logic [3:0]  desc;
    logic        accept;

    assign lo       = s_tdata[63:0];
    assign hi       = s_tdata[127:64];
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    assign tag_n     = lo[63:60];
    assign tag_rc    = (tag_n == 4'd0) ? 5'd16 : {1'b0, tag_n};
    assign tag_loop  = lo[14:0];
    assign tag_fmt   = lo[59:58];
    assign tag_prod  = {15'd0, tag_rc} * {5'd0, tag_loop};
    assign tag_total = (tag_fmt <= 2'd1) ? tag_prod[18:0] : {4'd0, tag_loop};
    assign idx_inc   = idx_reg + 19'd1;
    assign desc      = list_reg[{slot_reg, 2'b00} +: 4];

    always_comb
    begin
        phase_next = phase_reg;
        fmt_next   = fmt_reg;
        rc_next    = rc_reg;
        list_next  = list_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        slot_next  = slot_reg;
        push       = 1'b0;
        push_cmd   = '{dual: 1'b0, addr: lo[7:0], v0: lo, v1: hi};
        if (accept)
        begin
            if (!phase_reg)
            begin
                fmt_next   = tag_fmt;
                rc_next    = tag_rc;
                list_next  = hi;
                total_next = tag_total;
                idx_next   = 19'd0;
                slot_next  = 4'd0;
                phase_next = (tag_total != 19'd0);
                if (lo[TAG_PRE_BIT])
                begin
                    push          = 1'b1;
                    push_cmd.addr = ADDR_PRIM;
                    push_cmd.v0   = {54'd0, lo[56:47]};
                end
            end
            else
            begin
                idx_next   = idx_inc;
                phase_next = (idx_inc != total_reg);
                slot_next  = ({1'b0, slot_reg} == rc_reg - 5'd1) ? 4'd0 : slot_reg + 4'd1;
                if (fmt_reg == FMT_IMAGE)
                begin
                    push          = 1'b1;
                    push_cmd.dual = 1'b1;
                    push_cmd.addr = ADDR_HWREG;
                end
                else if (desc == DESC_AD)
                begin
                    push          = 1'b1;
                    push_cmd.addr = hi[7:0];
                end
                else if (desc != DESC_NOP_B && desc != DESC_NOP_F)
                begin
                    push          = 1'b1;
                    push_cmd.addr = {4'd0, desc};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            fmt_reg   <= 2'd0;
            rc_reg    <= 5'd0;
            list_reg  <= 64'd0;
            idx_reg   <= 19'd0;
            total_reg <= 19'd0;
            slot_reg  <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fmt_reg   <= fmt_next;
            rc_reg    <= rc_next;
            list_reg  <= list_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

>>> hdl/gptu_queue.sv
// Command queue between front and back ends.
// Depends on gptu_pkg for the command and status types.
module gptu_queue
    import gptu_pkg::*;
#(
    parameter int DEPTH = GPTU_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (cnt_reg == CW'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (do_pop)
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> hdl/gptu_back.sv
// Back end: expands queued commands into register write words.
// Depends on gptu_pkg; drives the output register of the master side.
module gptu_back
    import gptu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic [7:0]  addr_reg, addr_next;
    logic [63:0] val_reg, val_next;
    logic        last_reg, last_next;
    logic [63:0] hold_reg, hold_next;
    logic        load;

    assign load     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {val_reg, addr_reg};
    assign m_tlast  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        hold_next  = hold_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                addr_next  = ADDR_HWREG;
                val_next   = hold_reg;
                last_next  = 1'b1;
            end
            else if (!q_stat.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                pend_next  = head.dual;
                addr_next  = head.addr;
                val_next   = head.v0;
                last_next  = !head.dual;
                hold_next  = head.v1;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        val_reg  <= val_next;
        last_reg <= last_next;
        hold_reg <= hold_next;
    end

endmodule

>>> hdl/gptu_checker.sv
// Port-level checks for the graphics packet tag unpacker, bound to the top.
// Depends on gptu_pkg and graphics_packet_tag_unpacker_top.
module gptu_checker
    import gptu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_first_hwreg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[7:0] == ADDR_HWREG)
        else $error("non-final word not an image write");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && m_tdata[7:0] == ADDR_HWREG)
        else $error("image high half did not follow");

endmodule

bind graphics_packet_tag_unpacker_top gptu_checker u_gptu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
